/* rtl/core/aesccm_pkg.sv */
// Shared types, constants and AES round functions for the CCM engine.
`default_nettype none
package aesccm_pkg;

    // Work items of the function field.
    localparam logic [2:0] FUNC_START  = 3'd0;
    localparam logic [2:0] FUNC_AAD    = 3'd1;
    localparam logic [2:0] FUNC_ENC    = 3'd2;
    localparam logic [2:0] FUNC_DEC    = 3'd3;
    localparam logic [2:0] FUNC_FINISH = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_KSIZE = 3'd4;
    localparam logic [2:0] REG_TAG   = 3'd5;
    localparam logic [2:0] REG_NONCE = 3'd6;

    // Key size codes.
    localparam logic [1:0] KSIZE_128 = 2'd0;
    localparam logic [1:0] KSIZE_192 = 2'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  byte_count;
        logic [63:0] aad_total;
        logic [63:0] msg_total;
    } t_in_word;

    typedef struct packed {
        logic [63:0] out_hi;
        logic [63:0] out_lo;
        logic [4:0]  out_count;
        logic        is_tag;
    } t_out_word;

    // Round key write from the key schedule to the cipher's key store.
    typedef struct packed {
        logic         we;
        logic [3:0]   addr;
        logic [127:0] data;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0]   a [16];
        logic [7:0]   n [16];
        logic [7:0]   m [16];
        logic [7:0]   al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                n[c*4+i] = SBOX[a[((c+i) % 4)*4+i]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            al = n[c*4] ^ n[c*4+1] ^ n[c*4+2] ^ n[c*4+3];
            m[c*4]   = n[c*4]   ^ al ^ xtime(n[c*4]   ^ n[c*4+1]);
            m[c*4+1] = n[c*4+1] ^ al ^ xtime(n[c*4+1] ^ n[c*4+2]);
            m[c*4+2] = n[c*4+2] ^ al ^ xtime(n[c*4+2] ^ n[c*4+3]);
            m[c*4+3] = n[c*4+3] ^ al ^ xtime(n[c*4+3] ^ n[c*4]);
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = (last ? n[i] : m[i]) ^ rk[127-8*i -: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/aesccm_keyexp.sv */
// Iterative AES key schedule: one 32-bit schedule word per cycle into the key store.
`default_nettype none
module aesccm_keyexp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [255:0]         i_key,
    input  wire logic [1:0]           i_key_size,
    output aesccm_pkg::t_rk_wr        o_wr,
    output logic                      o_done
);
    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_idx;
    logic [2:0]   r_mod;
    logic [7:0]   r_rcon;
    logic [3:0]   r_nk;
    logic [5:0]   r_last;
    logic [255:0] r_key;
    logic [31:0]  r_win [8];
    logic [95:0]  r_acc;
    logic [31:0]  prev;
    logic [31:0]  old;
    logic [31:0]  tw;
    logic [31:0]  word;

    function automatic logic [31:0] sub_word_rot(input logic [31:0] w);
        return aesccm_pkg::sub_word({w[23:0], w[31:24]});
    endfunction

    // Next schedule word from the window of the last eight words.
    always_comb begin
        prev = r_win[7];
        unique case (r_nk)
            4'd4:    old = r_win[4];
            4'd6:    old = r_win[2];
            default: old = r_win[0];
        endcase
        priority if (r_mod == 3'd0) begin
            tw = sub_word_rot(prev) ^ {r_rcon, 24'h0};
        end else if (r_nk == 4'd8 && r_mod == 3'd4) begin
            tw = aesccm_pkg::sub_word(prev);
        end else begin
            tw = prev;
        end
        word = ({2'b00, r_idx} < {4'b0, r_nk}) ? r_key[255:224] : (old ^ tw);
    end

    // Sequencer over the schedule words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= 6'd0;
                r_mod  <= 3'd0;
                r_rcon <= 8'h01;
                r_key  <= i_key;
                unique case (i_key_size)
                    aesccm_pkg::KSIZE_128: begin
                        r_nk   <= 4'd4;
                        r_last <= 6'd43;
                    end
                    aesccm_pkg::KSIZE_192: begin
                        r_nk   <= 4'd6;
                        r_last <= 6'd51;
                    end
                    default: begin
                        r_nk   <= 4'd8;
                        r_last <= 6'd59;
                    end
                endcase
            end else if (r_busy) begin
                r_key <= {r_key[223:0], 32'h0};
                for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
                r_win[7] <= word;
                r_acc    <= {r_acc[63:0], word};
                if (r_mod == 3'(r_nk - 4'd1)) begin
                    r_mod <= 3'd0;
                end else begin
                    r_mod <= r_mod + 3'd1;
                end
                if (r_mod == 3'd0 && {2'b00, r_idx} >= {4'b0, r_nk}) begin
                    r_rcon <= aesccm_pkg::xtime(r_rcon);
                end
                r_idx <= r_idx + 6'd1;
                if (r_idx == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A full round key row is written on every fourth word.
    assign o_wr.we   = r_busy && !i_start && (r_idx[1:0] == 2'd3);
    assign o_wr.addr = r_idx[5:2];
    assign o_wr.data = {r_acc, word};
    assign o_done    = r_done;

endmodule
`default_nettype wire

/* rtl/core/aesccm_cipher.sv */
// Round-iterative AES block encryption with the round key store.
`default_nettype none
module aesccm_cipher (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire aesccm_pkg::t_rk_wr   i_wr,
    input  wire logic [3:0]           i_nr,
    input  wire logic                 i_start,
    input  wire logic [127:0]         i_block,
    output logic                      o_done,
    output logic [127:0]              o_block
);
    logic [127:0] r_mem [15];
    logic [127:0] r_rk;
    logic [127:0] r_in;
    logic [127:0] r_s;
    logic [3:0]   r_round;
    logic [3:0]   r_nr;
    logic         r_busy;
    logic         r_done;
    logic         rd_en;
    logic [3:0]   rd_addr;

    // Round key read one round ahead.
    assign rd_en   = i_start || (r_busy && r_round != r_nr);
    assign rd_addr = i_start ? 4'd0 : r_round + 4'd1;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rk <= r_mem[rd_addr];
        end
    end

    // Round sequencer: whitening, then one round per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd0;
                r_nr    <= i_nr;
                r_in    <= i_block;
            end else if (r_busy) begin
                if (r_round == 4'd0) begin
                    r_s <= r_in ^ r_rk;
                end else begin
                    r_s <= aesccm_pkg::aes_round(r_s, r_rk, r_round == r_nr);
                end
                r_round <= r_round + 4'd1;
                if (r_round == r_nr) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_block = r_s;

endmodule
`default_nettype wire

/* rtl/core/aes_ccm_authenticated_cipher.sv */
// Top level of the AES-CCM engine: configuration port, CCM sequencer and output register.
`default_nettype none
// AES-CCM engine with 128, 192 and 256-bit keys. One word is taken at a time; the input
// is ready again only when the sequencer is back in idle. Every block goes through a
// single round-iterative AES unit, which holds the sequencer from the launch of an
// encryption to its result. A start word runs the key schedule, one schedule word per
// cycle, and then two encryptions. An encrypt or decrypt word takes two encryptions; an
// AAD word none, one or two, and a finish word none. A result waits in the output
// register while the next word is taken. Tags are returned, not compared.
module aes_ccm_authenticated_cipher (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [5:0]             paddr,
    input  wire logic [63:0]            pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire aesccm_pkg::t_in_word   i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output aesccm_pkg::t_out_word       o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY  = 3'd1;
    localparam logic [2:0] S_SZ   = 3'd2;
    localparam logic [2:0] S_GO   = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_ACHK = 3'd5;
    localparam logic [2:0] S_PAY  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [1:0] D_MAC = 2'd0;
    localparam logic [1:0] D_S0  = 2'd1;
    localparam logic [1:0] D_KS  = 2'd2;

    // Configuration registers.
    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic [1:0]  r_ksize;
    logic [4:0]  r_tagb;
    logic [3:0]  r_nonceb;

    // CCM state.
    logic [2:0]   r_state;
    logic [2:0]   r_ret;
    logic [1:0]   r_dst;
    logic [1:0]   r_phase;
    logic [127:0] r_mac, r_ctr, r_s0, r_carry, r_ks, r_blk, r_data, r_res;
    logic [4:0]   r_fill;
    logic [63:0]  r_rem;
    logic [3:0]   r_q;
    logic [3:0]   r_nr;
    logic         r_dec;
    logic [4:0]   r_n;
    logic [4:0]   r_rcnt;
    logic         r_rtag;
    logic         r_ovalid;
    aesccm_pkg::t_out_word r_odata;

    logic         cfg_wr;
    logic         accept;
    logic [127:0] din;
    logic [4:0]   nclamp;
    logic [4:0]   teff;
    logic [3:0]   nb;
    logic [3:0]   q;
    logic [127:0] qm;
    logic [127:0] b0, ctr0, pre;
    logic [4:0]   pfill;
    logic [4:0]   nuse;
    logic [127:0] dm;
    logic [255:0] comb;
    logic [5:0]   newfill;
    logic [63:0]  ctr_mask;
    logic [63:0]  ctr_inc;
    logic [127:0] ctr_next;
    logic [127:0] res, plain;
    logic [127:0] cmask;
    aesccm_pkg::t_rk_wr kx_wr;
    logic         kx_done;
    logic         cp_done;
    logic [127:0] cp_out;

    function automatic logic [127:0] front_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
        return m;
    endfunction

    function automatic logic [127:0] low_mask(input logic [3:0] k);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) m[8*i +: 8] = (4'(i) < k) ? 8'hff : 8'h00;
        return m;
    endfunction

    // APB configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0   <= 64'h0;
            r_key1   <= 64'h0;
            r_key2   <= 64'h0;
            r_key3   <= 64'h0;
            r_ksize  <= 2'd0;
            r_tagb   <= 5'd16;
            r_nonceb <= 4'd12;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                aesccm_pkg::REG_KEY0:  r_key0   <= pwdata;
                aesccm_pkg::REG_KEY1:  r_key1   <= pwdata;
                aesccm_pkg::REG_KEY2:  r_key2   <= pwdata;
                aesccm_pkg::REG_KEY3:  r_key3   <= pwdata;
                aesccm_pkg::REG_KSIZE: r_ksize  <= pwdata[1:0];
                aesccm_pkg::REG_TAG:   r_tagb   <= pwdata[4:0];
                aesccm_pkg::REG_NONCE: r_nonceb <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            aesccm_pkg::REG_KEY0:  prdata = r_key0;
            aesccm_pkg::REG_KEY1:  prdata = r_key1;
            aesccm_pkg::REG_KEY2:  prdata = r_key2;
            aesccm_pkg::REG_KEY3:  prdata = r_key3;
            aesccm_pkg::REG_KSIZE: prdata = {62'h0, r_ksize};
            aesccm_pkg::REG_TAG:   prdata = {59'h0, r_tagb};
            aesccm_pkg::REG_NONCE: prdata = {60'h0, r_nonceb};
            default:               prdata = 64'h0;
        endcase
    end

    // Shared units: key schedule and AES block cipher.
    aesccm_keyexp u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && i_data.func == aesccm_pkg::FUNC_START),
        .i_key      ({r_key0, r_key1, r_key2, r_key3}),
        .i_key_size (r_ksize),
        .o_wr       (kx_wr),
        .o_done     (kx_done)
    );

    aesccm_cipher u_cipher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (kx_wr),
        .i_nr    (r_nr),
        .i_start (r_state == S_GO),
        .i_block (r_blk),
        .o_done  (cp_done),
        .o_block (cp_out)
    );

    // Start word: B0, counter block zero and the AAD length prefix.
    always_comb begin
        din    = {i_data.data_hi, i_data.data_lo};
        nclamp = (i_data.byte_count > 5'd16) ? 5'd16 : i_data.byte_count;
        priority if (r_tagb < 5'd4) begin
            teff = 5'd4;
        end else if (r_tagb > 5'd16) begin
            teff = 5'd16;
        end else begin
            teff = {r_tagb[4:1], 1'b0};
        end
        priority if (r_nonceb < 4'd7) begin
            nb = 4'd7;
        end else if (r_nonceb > 4'd13) begin
            nb = 4'd13;
        end else begin
            nb = r_nonceb;
        end
        q    = 4'd15 - nb;
        qm   = low_mask(q);
        b0   = ({1'b0, i_data.aad_total != 64'h0, 3'((teff - 5'd2) >> 1), 3'(q - 4'd1),
                 din[127:8]} & ~qm) | ({64'h0, i_data.msg_total} & qm);
        ctr0 = {5'd0, 3'(q - 4'd1), din[127:8]} & ~qm;
        priority if (i_data.aad_total < 64'd65280) begin
            pre   = {i_data.aad_total[15:0], 112'h0};
            pfill = 5'd2;
        end else if (i_data.aad_total < 64'h1_0000_0000) begin
            pre   = {16'hfffe, i_data.aad_total[31:0], 80'h0};
            pfill = 5'd6;
        end else begin
            pre   = {16'hffff, i_data.aad_total, 48'h0};
            pfill = 5'd10;
        end
    end

    // AAD word: append the bytes behind those already held.
    always_comb begin
        nuse    = (r_rem < {59'h0, nclamp}) ? r_rem[4:0] : nclamp;
        dm      = din & front_mask(nuse);
        comb    = {r_carry, 128'h0} | ({dm, 128'h0} >> {r_fill, 3'b000});
        newfill = {1'b0, r_fill} + {1'b0, nuse};
    end

    // Counter step over the low q bytes only.
    always_comb begin
        ctr_mask = 64'(low_mask(r_q));
        ctr_inc  = r_ctr[63:0] + 64'd1;
        ctr_next = {r_ctr[127:64], (ctr_inc & ctr_mask) | (r_ctr[63:0] & ~ctr_mask)};
    end

    // Payload result and the plaintext that enters the MAC.
    always_comb begin
        cmask = front_mask(r_n);
        res   = (r_data ^ r_ks) & cmask;
        plain = r_dec ? res : (r_data & cmask);
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // CCM sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_ovalid <= 1'b0;
            r_mac    <= 128'h0;
            r_ctr    <= 128'h0;
            r_s0     <= 128'h0;
            r_carry  <= 128'h0;
            r_fill   <= 5'd0;
            r_rem    <= 64'h0;
            r_q      <= 4'd3;
            r_nr     <= 4'd10;
        end else begin
            // The output register reloads itself in S_OUT.
            if (r_ovalid && i_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_data <= din;
                        r_n    <= nclamp;
                        r_dec  <= (i_data.func == aesccm_pkg::FUNC_DEC);
                        unique case (i_data.func)
                            aesccm_pkg::FUNC_START: begin
                                r_q   <= q;
                                r_nr  <= (r_ksize == aesccm_pkg::KSIZE_128) ? 4'd10 :
                                         (r_ksize == aesccm_pkg::KSIZE_192) ? 4'd12 : 4'd14;
                                r_blk <= b0;
                                r_ctr <= ctr0;
                                r_rem <= i_data.aad_total;
                                if (i_data.aad_total != 64'h0) begin
                                    r_carry <= pre;
                                    r_fill  <= pfill;
                                    r_phase <= PH_HEADER;
                                end else begin
                                    r_carry <= 128'h0;
                                    r_fill  <= 5'd0;
                                    r_phase <= PH_BODY;
                                end
                                r_state <= S_KEY;
                            end
                            aesccm_pkg::FUNC_AAD: begin
                                if (r_phase == PH_HEADER && nclamp != 5'd0) begin
                                    r_rem <= r_rem - {59'h0, nuse};
                                    if (newfill[4] || newfill[5]) begin
                                        r_blk   <= r_mac ^ comb[255:128];
                                        r_carry <= comb[127:0];
                                        r_fill  <= 5'(newfill - 6'd16);
                                        r_dst   <= D_MAC;
                                        r_ret   <= S_ACHK;
                                        r_state <= S_GO;
                                    end else begin
                                        r_carry <= comb[255:128];
                                        r_fill  <= newfill[4:0];
                                        r_state <= S_ACHK;
                                    end
                                end
                            end
                            aesccm_pkg::FUNC_ENC, aesccm_pkg::FUNC_DEC: begin
                                if (r_phase == PH_BODY && nclamp != 5'd0) begin
                                    r_blk   <= r_ctr;
                                    r_ctr   <= ctr_next;
                                    r_dst   <= D_KS;
                                    r_ret   <= S_PAY;
                                    r_state <= S_GO;
                                end
                            end
                            aesccm_pkg::FUNC_FINISH: begin
                                if (r_phase == PH_BODY) begin
                                    r_res   <= (r_mac ^ r_s0) & front_mask(teff);
                                    r_rcnt  <= teff;
                                    r_rtag  <= 1'b1;
                                    r_phase <= PH_IDLE;
                                    r_state <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_KEY: begin
                    if (kx_done) begin
                        r_dst   <= D_MAC;
                        r_ret   <= S_SZ;
                        r_state <= S_GO;
                    end
                end
                S_SZ: begin
                    r_blk   <= r_ctr;
                    r_ctr   <= ctr_next;
                    r_dst   <= D_S0;
                    r_ret   <= S_IDLE;
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (cp_done) begin
                        unique case (r_dst)
                            D_MAC:   r_mac <= cp_out;
                            D_S0:    r_s0  <= cp_out;
                            default: r_ks  <= cp_out;
                        endcase
                        r_state <= r_ret;
                    end
                end
                S_ACHK: begin
                    // Close the header once all AAD bytes are in.
                    r_state <= S_IDLE;
                    if (r_rem == 64'h0) begin
                        r_phase <= PH_BODY;
                        if (r_fill != 5'd0) begin
                            r_blk   <= r_mac ^ r_carry;
                            r_carry <= 128'h0;
                            r_fill  <= 5'd0;
                            r_dst   <= D_MAC;
                            r_ret   <= S_IDLE;
                            r_state <= S_GO;
                        end
                    end
                end
                S_PAY: begin
                    r_res   <= res;
                    r_rcnt  <= r_n;
                    r_rtag  <= 1'b0;
                    r_blk   <= r_mac ^ plain;
                    r_dst   <= D_MAC;
                    r_ret   <= S_OUT;
                    r_state <= S_GO;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_odata.out_hi    <= r_res[127:64];
                        r_odata.out_lo    <= r_res[63:0];
                        r_odata.out_count <= r_rcnt;
                        r_odata.is_tag    <= r_rtag;
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

`ifndef SYNTHESIS
    // The carry buffer never holds a whole block between words.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < 5'd16))
        else $error("carry fill reached a full block in idle");

    // A start word always runs the key schedule before anything else.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.func == aesccm_pkg::FUNC_START) |=> (r_state == S_KEY))
        else $error("start word did not enter key schedule");

    // A pending result is not dropped before it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid)
        else $error("result dropped while stalled");

    // The cipher only reports completion while the sequencer waits for it.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cp_done |-> (r_state == S_WAIT))
        else $error("cipher finished outside a wait");
`endif

endmodule
`default_nettype wire

/* sim/aes_ccm_checker.sv */
// Checker for the CCM engine: predicts every output word and compares it with the block.
`timescale 1ns / 100ps
module aes_ccm_checker (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [5:0] paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic      pready,
    input  wire logic      i_valid,
    input  wire logic      i_in_ready,
    input  wire aesccm_pkg::t_in_word  i_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_ready,
    input  wire aesccm_pkg::t_out_word i_out_data,
    output int             o_errors,
    output int             o_pending
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_HEADER,
        SEQ_BODY
    } t_seq;

    // Configuration shadow.
    logic [63:0]  key_words [4];
    logic [1:0]   key_size;
    logic [4:0]   tag_cfg;
    logic [3:0]   nonce_cfg;

    // Mode state of the engine.
    logic [127:0] mac_state;
    logic [127:0] ctr_state;
    logic [127:0] s0_state;
    logic [127:0] aad_buf;
    int           aad_fill;
    logic [63:0]  aad_left;
    logic [127:0] round_keys [15];
    int           rounds;
    int           q_len;
    t_seq         seq;

    aesccm_pkg::t_out_word expected_words [$];
    int           mismatch_total;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {aesccm_pkg::SBOX[w[31:24]], aesccm_pkg::SBOX[w[23:16]],
                aesccm_pkg::SBOX[w[15:8]], aesccm_pkg::SBOX[w[7:0]]};
    endfunction

    // Key schedule into the round key array.
    function automatic void load_round_keys();
        logic [255:0] kbits;
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   rc;
        int           nk;
        kbits = {key_words[0], key_words[1], key_words[2], key_words[3]};
        nk = (key_size == 2'd0) ? 4 : (key_size == 2'd1) ? 6 : 8;
        rounds = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++) w[i] = kbits[255-32*i -: 32];
        for (int i = nk; i < 4 * (rounds + 1); i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]});
                t[31:24] = t[31:24] ^ rc;
                rc = gf_double(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int r = 0; r <= rounds; r++) begin
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        end
    endfunction

    // Forward AES of one block with the current round keys.
    function automatic logic [127:0] cipher(input logic [127:0] blk);
        logic [127:0] st;
        logic [7:0]   s [16];
        logic [7:0]   n [16];
        logic [7:0]   a0, a1, a2, a3, al;
        st = blk ^ round_keys[0];
        for (int r = 1; r <= rounds; r++) begin
            for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) n[c*4+i] = aesccm_pkg::SBOX[s[((c+i) % 4)*4+i]];
            end
            if (r < rounds) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = n[c*4]; a1 = n[c*4+1]; a2 = n[c*4+2]; a3 = n[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    n[c*4]   = a0 ^ al ^ gf_double(a0 ^ a1);
                    n[c*4+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                    n[c*4+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                    n[c*4+3] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[127-8*i -: 8] = n[i] ^ round_keys[r][127-8*i -: 8];
        end
        return st;
    endfunction

    function automatic void mac_absorb(input logic [127:0] blk);
        mac_state = cipher(mac_state ^ blk);
    endfunction

    // Append one byte behind the AAD prefix; full blocks go into the MAC.
    function automatic void aad_byte(input logic [7:0] b);
        aad_buf[127-8*(aad_fill % 16) -: 8] = b;
        aad_fill++;
        if (aad_fill >= 16) begin
            mac_absorb(aad_buf);
            aad_buf = '0;
            aad_fill = 0;
        end
    endfunction

    // Only the low q bytes of the counter count.
    function automatic void bump_counter();
        logic [7:0] b;
        for (int i = 15; i >= 16 - q_len; i--) begin
            b = ctr_state[127-8*i -: 8] + 8'd1;
            ctr_state[127-8*i -: 8] = b;
            if (b != 8'd0) break;
        end
    endfunction

    function automatic int tag_len();
        int t;
        t = tag_cfg;
        if (t < 4) t = 4;
        if (t > 16) t = 16;
        return t & ~1;
    endfunction

    // Advance the engine model by one input word; flags a result when one is due.
    function automatic void step_engine(input aesccm_pkg::t_in_word w, output bit has_out,
                                        output aesccm_pkg::t_out_word res);
        logic [127:0] d, b, ks, outb, plain;
        int           n, nb, t, k;
        d = {w.data_hi, w.data_lo};
        n = (w.byte_count > 5'd16) ? 16 : int'(w.byte_count);
        has_out = 1'b0;
        res = '0;
        case (w.func)
            aesccm_pkg::FUNC_START: begin
                nb = nonce_cfg;
                if (nb < 7) nb = 7;
                if (nb > 13) nb = 13;
                q_len = 15 - nb;
                t = tag_len();
                load_round_keys();
                b = '0;
                b[127:120] = ((w.aad_total != 0) ? 8'h40 : 8'h00) | 8'((t - 2) / 2 * 8) |
                             8'(q_len - 1);
                for (int i = 1; i <= nb; i++) b[127-8*i -: 8] = d[127-8*(i-1) -: 8];
                for (int i = nb + 1; i < 16; i++) b[127-8*i -: 8] = 8'(w.msg_total >> (8*(15-i)));
                mac_state = cipher(b);
                aad_buf = '0;
                aad_fill = 0;
                aad_left = w.aad_total;
                if (w.aad_total != 0) begin
                    if (w.aad_total < 64'd65280) begin
                        aad_byte(w.aad_total[15:8]);
                        aad_byte(w.aad_total[7:0]);
                    end else begin
                        k = (w.aad_total < 64'h1_0000_0000) ? 4 : 8;
                        aad_byte(8'hff);
                        aad_byte((k == 4) ? 8'hfe : 8'hff);
                        for (int i = 0; i < k; i++) aad_byte(8'(w.aad_total >> (8*(k-1-i))));
                    end
                    seq = SEQ_HEADER;
                end else begin
                    seq = SEQ_BODY;
                end
                ctr_state = '0;
                ctr_state[127:120] = 8'(q_len - 1);
                for (int i = 1; i <= nb; i++) ctr_state[127-8*i -: 8] = d[127-8*(i-1) -: 8];
                s0_state = cipher(ctr_state);
                bump_counter();
            end
            aesccm_pkg::FUNC_AAD: begin
                if (seq == SEQ_HEADER && n != 0) begin
                    for (int i = 0; i < n && aad_left != 0; i++) begin
                        aad_byte(d[127-8*i -: 8]);
                        aad_left--;
                    end
                    if (aad_left == 0) begin
                        if (aad_fill != 0) begin
                            mac_absorb(aad_buf);
                            aad_buf = '0;
                            aad_fill = 0;
                        end
                        seq = SEQ_BODY;
                    end
                end
            end
            aesccm_pkg::FUNC_ENC, aesccm_pkg::FUNC_DEC: begin
                if (seq == SEQ_BODY && n != 0) begin
                    ks = cipher(ctr_state);
                    bump_counter();
                    outb = '0;
                    plain = '0;
                    for (int i = 0; i < n; i++) begin
                        outb[127-8*i -: 8] = d[127-8*i -: 8] ^ ks[127-8*i -: 8];
                        plain[127-8*i -: 8] = (w.func == aesccm_pkg::FUNC_ENC)
                                              ? d[127-8*i -: 8] : outb[127-8*i -: 8];
                    end
                    mac_absorb(plain);
                    has_out = 1'b1;
                    res.out_hi = outb[127:64];
                    res.out_lo = outb[63:0];
                    res.out_count = 5'(n);
                    res.is_tag = 1'b0;
                end
            end
            aesccm_pkg::FUNC_FINISH: begin
                if (seq == SEQ_BODY) begin
                    t = tag_len();
                    outb = mac_state ^ s0_state;
                    for (int i = t; i < 16; i++) outb[127-8*i -: 8] = 8'h00;
                    has_out = 1'b1;
                    res.out_hi = outb[127:64];
                    res.out_lo = outb[63:0];
                    res.out_count = 5'(t);
                    res.is_tag = 1'b1;
                    seq = SEQ_IDLE;
                end
            end
            default: ;
        endcase
    endfunction

    // Track configuration, predict accepted words and check results.
    always @(posedge i_clk) begin
        bit                    has_out;
        aesccm_pkg::t_out_word predicted;
        aesccm_pkg::t_out_word exp_word;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_words[i] = '0;
            key_size = 2'd0;
            tag_cfg = 5'd16;
            nonce_cfg = 4'd12;
            mac_state = '0;
            ctr_state = '0;
            s0_state = '0;
            aad_buf = '0;
            aad_fill = 0;
            aad_left = '0;
            rounds = 10;
            q_len = 3;
            seq = SEQ_IDLE;
            expected_words.delete();
            mismatch_total = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    aesccm_pkg::REG_KEY0:  key_words[0] = pwdata;
                    aesccm_pkg::REG_KEY1:  key_words[1] = pwdata;
                    aesccm_pkg::REG_KEY2:  key_words[2] = pwdata;
                    aesccm_pkg::REG_KEY3:  key_words[3] = pwdata;
                    aesccm_pkg::REG_KSIZE: key_size = pwdata[1:0];
                    aesccm_pkg::REG_TAG:   tag_cfg = pwdata[4:0];
                    aesccm_pkg::REG_NONCE: nonce_cfg = pwdata[3:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out_data);
                    mismatch_total++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (exp_word.out_hi != i_out_data.out_hi ||
                        exp_word.out_lo != i_out_data.out_lo ||
                        exp_word.out_count != i_out_data.out_count ||
                        exp_word.is_tag != i_out_data.is_tag) begin
                        $display("%0t: mismatch expected %h_%h cnt %0d tag %0b", $time,
                                 exp_word.out_hi, exp_word.out_lo, exp_word.out_count,
                                 exp_word.is_tag);
                        $display("%0t:            actual %h_%h cnt %0d tag %0b", $time,
                                 i_out_data.out_hi, i_out_data.out_lo,
                                 i_out_data.out_count, i_out_data.is_tag);
                        mismatch_total++;
                    end
                end
            end
            if (i_valid && i_in_ready) begin
                step_engine(i_data, has_out, predicted);
                if (has_out) expected_words.push_back(predicted);
            end
        end
        o_errors <= mismatch_total;
        o_pending <= expected_words.size();
    end

endmodule

/* sim/aes_ccm_authenticated_cipher_test.sv */
// Testbench top for the CCM engine: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module aes_ccm_authenticated_cipher_test;

    localparam int IDLE_LIMIT = 20000;
    localparam int WORD_TARGET = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    aesccm_pkg::t_in_word  i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    aesccm_pkg::t_out_word o_data;

    int          errors;
    int          pending;
    int          words_sent = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    aes_ccm_authenticated_cipher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    aes_ccm_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_data(i_data),
        .i_out_valid(o_valid), .i_ready(i_ready), .i_out_data(o_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: bursts of ready separated by random stalls.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (i_ready) begin
                hold = pick_gap();
                i_ready = (hold == 0);
            end else begin
                i_ready = 1'b1;
                hold = $urandom_range(0, 30);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one word and hold it until it is taken.
    task automatic send_word(input aesccm_pkg::t_in_word w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = w;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic make_word(input logic [2:0] f, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic [63:0] aad,
                             input logic [63:0] msg);
        aesccm_pkg::t_in_word w;
        w.func = f;
        w.data_hi = hi;
        w.data_lo = lo;
        w.byte_count = cnt;
        w.aad_total = aad;
        w.msg_total = msg;
        send_word(w);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain all results, let a start word finish, then load a new setting.
    task automatic configure(input int ph);
        logic [1:0] ks_list [6] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2};
        logic [4:0] tag_list [6] = '{5'd16, 5'd4, 5'd31, 5'd3, 5'd7, 5'd10};
        logic [3:0] nonce_list [6] = '{4'd13, 4'd7, 4'd0, 4'd15, 4'd12, 4'd9};
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        reg_write(aesccm_pkg::REG_KEY0, (ph == 1) ? '1 : (ph == 0) ? '0 : rand64());
        reg_write(aesccm_pkg::REG_KEY1, (ph == 1) ? '1 : rand64());
        reg_write(aesccm_pkg::REG_KEY2, (ph == 1) ? '1 : rand64());
        reg_write(aesccm_pkg::REG_KEY3, (ph == 1) ? '1 : rand64());
        reg_write(aesccm_pkg::REG_KSIZE, 64'(ks_list[ph]));
        reg_write(aesccm_pkg::REG_TAG, 64'(tag_list[ph]));
        reg_write(aesccm_pkg::REG_NONCE, 64'(nonce_list[ph]));
    endtask

    // One message: start, AAD, payload and, mostly, finish.
    task automatic run_message();
        int         aad_len, msg_len, rem, cnt;
        logic [2:0] dir;
        case ($urandom_range(0, 9))
            0, 1, 2: aad_len = 0;
            8:       aad_len = $urandom_range(49, 200);
            default: aad_len = $urandom_range(1, 48);
        endcase
        msg_len = $urandom_range(0, 64);
        make_word(aesccm_pkg::FUNC_START, rand64(), rand64(), 5'($urandom), 64'(aad_len),
                  ($urandom_range(0, 9) == 0) ? rand64() : 64'(msg_len));
        rem = aad_len;
        while (rem > 0) begin
            cnt = (rem >= 16) ? 16 : rem;
            if ($urandom_range(0, 9) == 0) cnt = 16;
            make_word(aesccm_pkg::FUNC_AAD, rand64(), rand64(), 5'(cnt), rand64(), rand64());
            rem -= cnt;
        end
        dir = $urandom_range(0, 1) ? aesccm_pkg::FUNC_ENC : aesccm_pkg::FUNC_DEC;
        rem = msg_len;
        while (rem > 0) begin
            cnt = (rem >= 16) ? 16 : rem;
            make_word(dir, rand64(), rand64(), 5'(cnt), rand64(), rand64());
            rem -= cnt;
        end
        if ($urandom_range(0, 19) != 0) begin
            make_word(aesccm_pkg::FUNC_FINISH, rand64(), rand64(), 5'($urandom), rand64(),
                      rand64());
        end
    endtask

    // Short directed part: ignored words, edge lengths and prefix forms.
    task automatic directed_words();
        make_word(aesccm_pkg::FUNC_FINISH, '0, '0, 5'd0, '0, '0);
        make_word(aesccm_pkg::FUNC_AAD, '1, '1, 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_ENC, '1, '1, 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_START, '0, '0, 5'd0, '0, '0);
        make_word(aesccm_pkg::FUNC_FINISH, '0, '0, 5'd0, '0, '0);
        make_word(aesccm_pkg::FUNC_START, '1, '1, 5'd31, 64'd20, '1);
        make_word(aesccm_pkg::FUNC_AAD, '1, '1, 5'd16, '1, '1);
        make_word(aesccm_pkg::FUNC_AAD, '1, '1, 5'd0, '1, '1);
        make_word(aesccm_pkg::FUNC_AAD, '1, '0, 5'd16, '1, '1);
        make_word(aesccm_pkg::FUNC_ENC, '1, '1, 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_DEC, '0, '1, 5'd5, '0, '0);
        make_word(aesccm_pkg::FUNC_ENC, '1, '0, 5'd31, '0, '0);
        make_word(aesccm_pkg::FUNC_ENC, '1, '1, 5'd0, '0, '0);
        make_word(3'd7, '1, '1, 5'd16, '1, '1);
        make_word(3'd5, '1, '1, 5'd16, '1, '1);
        make_word(aesccm_pkg::FUNC_FINISH, '1, '1, 5'd31, '1, '1);
        make_word(aesccm_pkg::FUNC_START, rand64(), rand64(), 5'd16, 64'd65280, 64'd1);
        make_word(aesccm_pkg::FUNC_AAD, rand64(), rand64(), 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_START, rand64(), rand64(), 5'd16, 64'h1_0000_0000, 64'd1);
        make_word(aesccm_pkg::FUNC_AAD, rand64(), rand64(), 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_START, rand64(), rand64(), 5'd16, 64'd65279, '0);
        make_word(aesccm_pkg::FUNC_AAD, rand64(), rand64(), 5'd16, '0, '0);
        make_word(aesccm_pkg::FUNC_START, rand64(), rand64(), 5'd16, 64'd1, 64'd3);
        make_word(aesccm_pkg::FUNC_AAD, rand64(), rand64(), 5'd1, '0, '0);
        make_word(aesccm_pkg::FUNC_FINISH, '0, '0, 5'd0, '0, '0);
    endtask

    // Stray words with fully random fields.
    task automatic noise_word();
        logic [63:0] aad;
        aad = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(0, 40));
        make_word(3'($urandom), rand64(), rand64(), 5'($urandom), aad, rand64());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            configure(ph);
            calm = (ph == 2);
            if (ph == 0) directed_words();
            while (words_sent < WORD_TARGET * (ph + 1) / 6) begin
                if ($urandom_range(0, 9) == 0) noise_word();
                run_message();
            end
        end
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
